>>> sv/mwpw_pkg.sv
package mwpw_pkg;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_TOP_LEFT     = 3'd0,
        CFG_TOP_RIGHT    = 3'd1,
        CFG_BOTTOM_LEFT  = 3'd2,
        CFG_BOTTOM_RIGHT = 3'd3,
        CFG_CELL_BOX     = 3'd4,
        CFG_FRAME_SIZE   = 3'd5,
        CFG_CENTRE       = 3'd6
    } t_cfg_idx;

    // Floor divider: 32 quotient bits, four per stage
    localparam int DIV_BITS = 4;
    localparam int DIV_STG  = 32 / DIV_BITS;

    // Square root of a 66-bit operand: 33 digit steps, three per stage
    localparam int SQRT_STEPS = 3;
    localparam int SQRT_STG   = 33 / SQRT_STEPS;

    // Reciprocal divider: four bits per stage, quotient register sized for
    // the widest fraction setting
    localparam int RCP_BITS = 4;
    localparam int RCP_QW   = 52;

    typedef struct packed {
        logic [3:0][31:0] corner_x;
        logic [3:0][31:0] corner_y;
        logic [15:0]      left;
        logic [15:0]      top;
        logic [15:0]      right;
        logic [15:0]      bottom;
        logic [15:0]      fw;
        logic [15:0]      fh;
        logic [31:0]      ctr_x;
        logic [31:0]      ctr_y;
    } t_cfg;

    // Everything one item carries down the pipeline
    typedef struct packed {
        logic [15:0]      px;
        logic [15:0]      py;
        logic             in_cell;
        logic [15:0]      ox;
        logic [15:0]      sx;
        logic [15:0]      oy;
        logic [15:0]      sy;
        logic [31:0]      wa;
        logic [31:0]      wb;
        logic [31:0]      wc;
        logic [31:0]      wd;
        logic [31:0]      den;
        logic [3:0][63:0] prx;
        logic [3:0][63:0] pry;
        logic [63:0]      numx;
        logic [63:0]      numy;
        logic             negx;
        logic             negy;
        logic [63:0]      magx;
        logic [63:0]      magy;
        logic [32:0]      remx;
        logic [32:0]      remy;
        logic [31:0]      x;
        logic [31:0]      y;
        logic             in_frame;
        logic [15:0]      col;
        logic [15:0]      row;
        logic [32:0]      dx;
        logic [32:0]      dy;
        logic [31:0]      ax;
        logic [31:0]      ay;
        logic [63:0]      sqx;
        logic [63:0]      sqy;
        logic             zero;
        logic [65:0]      sv;
        logic [35:0]      srem;
        logic [32:0]      sroot;
        logic [33:0]      rrem;
        logic [RCP_QW-1:0] rq;
        logic [31:0]      weight;
    } t_item;

endpackage

>>> sv/mwpw_interp.sv
module mwpw_interp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  mwpw_pkg::t_cfg    i_cfg,
    input  logic              i_vld,
    input  mwpw_pkg::t_item   i_item,
    output logic              o_vld,
    output mwpw_pkg::t_item   o_item
);

    localparam int NSTG = 5;

    mwpw_pkg::t_item r_stg [NSTG];
    mwpw_pkg::t_item n_stg [NSTG];
    logic [NSTG-1:0] r_vld;

    // offset and span on one axis; offset clamped, empty span forced to 1
    function automatic logic [31:0] f_axis(input logic [15:0] p, input logic [15:0] lo,
                                           input logic [15:0] hi);
        logic [15:0] s;
        logic [15:0] o;
        begin
            s = (hi > lo) ? 16'(hi - lo) : 16'd0;
            o = (p < lo) ? 16'd0 : 16'(p - lo);
            if (o > s) begin
                o = s;
            end
            if (s == 16'd0) begin
                o = 16'd0;
                s = 16'd1;
            end
            return {o, s};
        end
    endfunction

    always_comb begin
        mwpw_pkg::t_item t;
        logic [3:0][31:0] w;
        logic signed [64:0] tx;
        logic signed [64:0] ty;
        // axis offsets
        t = i_item;
        t.in_cell = (i_item.px >= i_cfg.left) && (i_item.px <= i_cfg.right) &&
                    (i_item.py >= i_cfg.top) && (i_item.py <= i_cfg.bottom);
        {t.ox, t.sx} = f_axis(i_item.px, i_cfg.left, i_cfg.right);
        {t.oy, t.sy} = f_axis(i_item.py, i_cfg.top, i_cfg.bottom);
        n_stg[0] = t;
        // corner weights
        t = r_stg[0];
        t.wa  = (t.sx - t.ox) * (t.sy - t.oy);
        t.wb  = t.ox * (t.sy - t.oy);
        t.wc  = (t.sx - t.ox) * t.oy;
        t.wd  = t.ox * t.oy;
        t.den = t.sx * t.sy;
        n_stg[1] = t;
        // weighted corners
        t = r_stg[1];
        w = {t.wd, t.wc, t.wb, t.wa};
        for (int i = 0; i < 4; i++) begin
            tx = $signed({1'b0, w[i]}) * $signed(i_cfg.corner_x[i]);
            ty = $signed({1'b0, w[i]}) * $signed(i_cfg.corner_y[i]);
            t.prx[i] = tx[63:0];
            t.pry[i] = ty[63:0];
        end
        n_stg[2] = t;
        // numerators
        t = r_stg[2];
        t.numx = t.prx[0] + t.prx[1] + t.prx[2] + t.prx[3];
        t.numy = t.pry[0] + t.pry[1] + t.pry[2] + t.pry[3];
        n_stg[3] = t;
        // sign and magnitude for the divider
        t = r_stg[3];
        t.negx = t.numx[63];
        t.negy = t.numy[63];
        t.magx = t.numx[63] ? -t.numx : t.numx;
        t.magy = t.numy[63] ? -t.numy : t.numy;
        n_stg[4] = t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NSTG; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_item = r_stg[NSTG-1];

endmodule

>>> sv/mwpw_fdiv.sv
module mwpw_fdiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  mwpw_pkg::t_item   i_item,
    output logic              o_vld,
    output mwpw_pkg::t_item   o_item
);

    localparam int NSTG = mwpw_pkg::DIV_STG + 1;

    mwpw_pkg::t_item r_stg [NSTG];
    mwpw_pkg::t_item n_stg [NSTG];
    logic [NSTG-1:0] r_vld;

    // restoring division; quotient shifts into the low word of the magnitude
    always_comb begin
        mwpw_pkg::t_item t;
        for (int k = 0; k < mwpw_pkg::DIV_STG; k++) begin
            if (k == 0) begin
                t = i_item;
                t.remx = {1'b0, i_item.magx[63:32]};
                t.remy = {1'b0, i_item.magy[63:32]};
            end else begin
                t = r_stg[k-1];
            end
            for (int j = 0; j < mwpw_pkg::DIV_BITS; j++) begin
                t.remx = {t.remx[31:0], t.magx[31]};
                t.magx[31:0] = {t.magx[30:0], 1'b0};
                if (t.remx >= {1'b0, t.den}) begin
                    t.remx = t.remx - {1'b0, t.den};
                    t.magx[0] = 1'b1;
                end
                t.remy = {t.remy[31:0], t.magy[31]};
                t.magy[31:0] = {t.magy[30:0], 1'b0};
                if (t.remy >= {1'b0, t.den}) begin
                    t.remy = t.remy - {1'b0, t.den};
                    t.magy[0] = 1'b1;
                end
            end
            n_stg[k] = t;
        end
        // floor: negative with remainder gives -q-1
        t = r_stg[mwpw_pkg::DIV_STG-1];
        if (!t.negx) begin
            t.x = t.magx[31:0];
        end else if (t.remx != '0) begin
            t.x = ~t.magx[31:0];
        end else begin
            t.x = -t.magx[31:0];
        end
        if (!t.negy) begin
            t.y = t.magy[31:0];
        end else if (t.remy != '0) begin
            t.y = ~t.magy[31:0];
        end else begin
            t.y = -t.magy[31:0];
        end
        n_stg[NSTG-1] = t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NSTG; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_item = r_stg[NSTG-1];

endmodule

>>> sv/mwpw_wgt.sv
module mwpw_wgt #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  mwpw_pkg::t_cfg    i_cfg,
    input  logic              i_vld,
    input  mwpw_pkg::t_item   i_item,
    output logic              o_vld,
    output mwpw_pkg::t_item   o_item
);

    localparam int F      = COORD_FRAC_BITS;
    localparam int RCP_NB = 2 * F + 1;
    localparam int RCP_ST = (RCP_NB + mwpw_pkg::RCP_BITS - 1) / mwpw_pkg::RCP_BITS;
    localparam int RCP_DW = RCP_ST * mwpw_pkg::RCP_BITS;
    localparam int SQ0    = 4;
    localparam int RC0    = SQ0 + mwpw_pkg::SQRT_STG;
    localparam int NSTG   = RC0 + RCP_ST + 1;

    mwpw_pkg::t_item r_stg [NSTG];
    mwpw_pkg::t_item n_stg [NSTG];
    logic [NSTG-1:0] r_vld;

    always_comb begin
        mwpw_pkg::t_item t;
        logic [47:0] fwq;
        logic [47:0] fhq;
        logic [64:0] sum;
        logic [35:0] test;
        // frame test, cell indexes, offsets from the centre
        t = i_item;
        fwq = 48'(i_cfg.fw) << F;
        fhq = 48'(i_cfg.fh) << F;
        t.in_frame = !t.x[31] && !t.y[31] && ({16'd0, t.x} < fwq) && ({16'd0, t.y} < fhq);
        t.col = t.in_frame ? 16'(t.x >> F) : 16'd0;
        t.row = t.in_frame ? 16'(t.y >> F) : 16'd0;
        t.dx = $signed({t.x[31], t.x}) - $signed({i_cfg.ctr_x[31], i_cfg.ctr_x});
        t.dy = $signed({t.y[31], t.y}) - $signed({i_cfg.ctr_y[31], i_cfg.ctr_y});
        n_stg[0] = t;
        // magnitudes
        t = r_stg[0];
        t.ax = t.dx[32] ? 32'(-t.dx) : t.dx[31:0];
        t.ay = t.dy[32] ? 32'(-t.dy) : t.dy[31:0];
        n_stg[1] = t;
        // squares
        t = r_stg[1];
        t.sqx = t.ax * t.ax;
        t.sqy = t.ay * t.ay;
        n_stg[2] = t;
        // squared distance, root preload
        t = r_stg[2];
        sum = {1'b0, t.sqx} + {1'b0, t.sqy};
        t.zero  = (sum == '0);
        t.sv    = {1'b0, sum};
        t.srem  = '0;
        t.sroot = '0;
        n_stg[3] = t;
        // integer square root, one digit pair a step
        for (int k = 0; k < mwpw_pkg::SQRT_STG; k++) begin
            t = r_stg[SQ0+k-1];
            for (int j = 0; j < mwpw_pkg::SQRT_STEPS; j++) begin
                t.srem = {t.srem[33:0], t.sv[65:64]};
                t.sv   = {t.sv[63:0], 2'b00};
                test   = {1'b0, t.sroot, 2'b01};
                if (t.srem >= test) begin
                    t.srem  = t.srem - test;
                    t.sroot = {t.sroot[31:0], 1'b1};
                end else begin
                    t.sroot = {t.sroot[31:0], 1'b0};
                end
            end
            n_stg[SQ0+k] = t;
        end
        // 2^(2F) / root, restoring
        for (int k = 0; k < RCP_ST; k++) begin
            t = r_stg[RC0+k-1];
            if (k == 0) begin
                t.rrem = '0;
                t.rq   = '0;
            end
            for (int j = 0; j < mwpw_pkg::RCP_BITS; j++) begin
                t.rrem = {t.rrem[32:0],
                          ((RCP_DW - 1 - (k * mwpw_pkg::RCP_BITS + j)) == 2 * F)};
                if (t.rrem >= {1'b0, t.sroot}) begin
                    t.rrem = t.rrem - {1'b0, t.sroot};
                    t.rq   = {t.rq[mwpw_pkg::RCP_QW-2:0], 1'b1};
                end else begin
                    t.rq   = {t.rq[mwpw_pkg::RCP_QW-2:0], 1'b0};
                end
            end
            n_stg[RC0+k] = t;
        end
        // weight select and saturation
        t = r_stg[NSTG-2];
        if (t.zero) begin
            t.weight = 32'd1 << F;
        end else if (!t.in_frame) begin
            t.weight = '0;
        end else if (|t.rq[mwpw_pkg::RCP_QW-1:32]) begin
            t.weight = '1;
        end else begin
            t.weight = t.rq[31:0];
        end
        n_stg[NSTG-1] = t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NSTG; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_item = r_stg[NSTG-1];

endmodule

>>> sv/mesh_warp_point_and_weight_unit.sv
// Mesh warp point and weight unit. Each canvas pixel item is mapped through one
// mesh cell by bilinear blending of the four configured corners (signed Q16.16
// by default, COORD_FRAC_BITS fraction bits), giving the source point, its
// truncated frame column and row, in-frame and inside-cell flags, and a blend
// weight: one at the optical centre, 1/distance in frame, zero otherwise,
// saturated. One item is accepted every clock while the output is not stalled;
// each item runs through the 32-bit floor divider (8 stages), the 33-step
// square root (11 stages) and the reciprocal divider, four quotient bits per
// stage. The whole pipeline holds while the output item is stalled.
// Configuration must be written only while the unit is empty; the unit itself
// does not enforce this.
module mesh_warp_point_and_weight_unit #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    // pixel items in
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_pixel_x,
    input  logic [15:0]        i_pixel_y,
    // result items out
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_source_x,
    output logic signed [31:0] o_source_y,
    output logic [15:0]        o_frame_col,
    output logic [15:0]        o_frame_row,
    output logic               o_in_frame,
    output logic               o_inside_cell,
    output logic [31:0]        o_weight
);

    mwpw_pkg::t_cfg  r_cfg;
    mwpw_pkg::t_item n_in;
    mwpw_pkg::t_item ip_item;
    mwpw_pkg::t_item dv_item;
    mwpw_pkg::t_item wt_item;
    logic            ip_vld;
    logic            dv_vld;
    logic            wt_vld;
    logic            en;

    // configuration registers; corners split into x (high word) and y
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (mwpw_pkg::t_cfg_idx'(i_cfg_index))
                mwpw_pkg::CFG_TOP_LEFT: begin
                    r_cfg.corner_x[0] <= i_cfg_data[63:32];
                    r_cfg.corner_y[0] <= i_cfg_data[31:0];
                end
                mwpw_pkg::CFG_TOP_RIGHT: begin
                    r_cfg.corner_x[1] <= i_cfg_data[63:32];
                    r_cfg.corner_y[1] <= i_cfg_data[31:0];
                end
                mwpw_pkg::CFG_BOTTOM_LEFT: begin
                    r_cfg.corner_x[2] <= i_cfg_data[63:32];
                    r_cfg.corner_y[2] <= i_cfg_data[31:0];
                end
                mwpw_pkg::CFG_BOTTOM_RIGHT: begin
                    r_cfg.corner_x[3] <= i_cfg_data[63:32];
                    r_cfg.corner_y[3] <= i_cfg_data[31:0];
                end
                mwpw_pkg::CFG_CELL_BOX: begin
                    r_cfg.left   <= i_cfg_data[63:48];
                    r_cfg.top    <= i_cfg_data[47:32];
                    r_cfg.right  <= i_cfg_data[31:16];
                    r_cfg.bottom <= i_cfg_data[15:0];
                end
                mwpw_pkg::CFG_FRAME_SIZE: begin
                    r_cfg.fw <= i_cfg_data[31:16];
                    r_cfg.fh <= i_cfg_data[15:0];
                end
                mwpw_pkg::CFG_CENTRE: begin
                    r_cfg.ctr_x <= i_cfg_data[63:32];
                    r_cfg.ctr_y <= i_cfg_data[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    // one enable for every stage: advance unless the output item is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_comb begin
        n_in    = '0;
        n_in.px = i_pixel_x;
        n_in.py = i_pixel_y;
    end

    // bilinear numerators
    mwpw_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_vld   (i_valid),
        .i_item  (n_in),
        .o_vld   (ip_vld),
        .o_item  (ip_item)
    );

    // floor division by the cell area
    mwpw_fdiv u_fdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (ip_vld),
        .i_item  (ip_item),
        .o_vld   (dv_vld),
        .o_item  (dv_item)
    );

    // frame test, distance, root and reciprocal
    mwpw_wgt #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_wgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_vld   (dv_vld),
        .i_item  (dv_item),
        .o_vld   (wt_vld),
        .o_item  (wt_item)
    );

    assign o_valid       = wt_vld;
    assign o_source_x    = $signed(wt_item.x);
    assign o_source_y    = $signed(wt_item.y);
    assign o_frame_col   = wt_item.col;
    assign o_frame_row   = wt_item.row;
    assign o_in_frame    = wt_item.in_frame;
    assign o_inside_cell = wt_item.in_cell;
    assign o_weight      = wt_item.weight;

`ifndef SYNTH
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result item shown straight after reset");

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_frame |-> o_frame_col == 16'd0 && o_frame_row == 16'd0)
        else $error("frame index set for a point out of frame");

    a_in_frame_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_frame |-> !o_source_x[31] && !o_source_y[31])
        else $error("in-frame flag on a negative source point");

    a_wgt_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_frame |->
            (o_weight == 32'd0 || o_weight == (32'd1 << COORD_FRAC_BITS)))
        else $error("out-of-frame weight neither zero nor unity");
`endif

endmodule
